>>> hw/rtl/dsfp_pkg.sv
// ----------------------------------------------------------------------------
// Damped spring force package
// Shared types and constants for the damped spring force pipeline.
// ----------------------------------------------------------------------------
package dsfp_pkg;

  localparam int unsigned SQRT_STEPS = 33;
  localparam int unsigned DIV_STEPS  = 17;

  typedef enum logic [1:0] {
    REG_STIFFNESS   = 2'd0,
    REG_DAMPING     = 2'd1,
    REG_REST_LENGTH = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               coincident;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic               sx;
    logic               sy;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic               coin;
  } vel_side_t;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    vel_side_t   vel;
  } root_side_t;

endpackage

>>> hw/rtl/dsfp_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 65-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module dsfp_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [64:0]          radicand,
  input  dsfp_pkg::root_side_t side_in,
  output logic                 out_valid,
  output logic [32:0]          root,
  output dsfp_pkg::root_side_t side_out
);
  import dsfp_pkg::*;

  logic        vld  [SQRT_STEPS];
  logic [65:0] rad  [SQRT_STEPS];
  logic [35:0] rem  [SQRT_STEPS];
  logic [32:0] acc  [SQRT_STEPS];
  root_side_t  side [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic        v_src;
    logic [65:0] r_src;
    logic [35:0] m_src;
    logic [32:0] q_src;
    root_side_t  s_src;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic        fit;

    if (j == 0) begin : g_head
      assign v_src = in_valid;
      assign r_src = {1'b0, radicand};
      assign m_src = '0;
      assign q_src = '0;
      assign s_src = side_in;
    end else begin : g_tail
      assign v_src = vld[j-1];
      assign r_src = rad[j-1];
      assign m_src = rem[j-1];
      assign q_src = acc[j-1];
      assign s_src = side[j-1];
    end

    assign shifted = {m_src[33:0], r_src[65:64]};
    assign trial   = {1'b0, q_src, 2'b01};
    assign fit     = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[j]  <= {r_src[63:0], 2'b00};
        rem[j]  <= fit ? shifted - trial : shifted;
        acc[j]  <= {q_src[31:0], fit};
        side[j] <= s_src;
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS-1];
  assign root      = acc[SQRT_STEPS-1];
  assign side_out  = side[SQRT_STEPS-1];

endmodule

>>> hw/rtl/dsfp_div.sv
// ----------------------------------------------------------------------------
// Pipelined unit direction divider
// Computes |dx| * 2^16 / d and |dy| * 2^16 / d, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dsfp_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [32:0]          dist_in,
  input  dsfp_pkg::root_side_t side_in,
  output logic                 out_valid,
  output logic [16:0]          qx,
  output logic [16:0]          qy,
  output logic [32:0]          dist_out,
  output dsfp_pkg::vel_side_t  side_out
);
  import dsfp_pkg::*;

  logic        vld  [DIV_STEPS];
  logic [32:0] rx   [DIV_STEPS];
  logic [32:0] ry   [DIV_STEPS];
  logic [16:0] accx [DIV_STEPS];
  logic [16:0] accy [DIV_STEPS];
  logic [32:0] dv   [DIV_STEPS];
  vel_side_t   side [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic        v_src;
    logic [32:0] rx_src;
    logic [32:0] ry_src;
    logic [16:0] qx_src;
    logic [16:0] qy_src;
    logic [32:0] d_src;
    vel_side_t   s_src;
    logic        fx;
    logic        fy;
    logic [33:0] shx;
    logic [33:0] shy;
    logic        fitx;
    logic        fity;

    if (j == 0) begin : g_head
      assign v_src  = in_valid;
      assign rx_src = {2'b00, side_in.ax[31:1]};
      assign ry_src = {2'b00, side_in.ay[31:1]};
      assign qx_src = '0;
      assign qy_src = '0;
      assign d_src  = dist_in;
      assign s_src  = side_in.vel;
      assign fx     = side_in.ax[0];
      assign fy     = side_in.ay[0];
    end else begin : g_tail
      assign v_src  = vld[j-1];
      assign rx_src = rx[j-1];
      assign ry_src = ry[j-1];
      assign qx_src = accx[j-1];
      assign qy_src = accy[j-1];
      assign d_src  = dv[j-1];
      assign s_src  = side[j-1];
      assign fx     = 1'b0;
      assign fy     = 1'b0;
    end

    assign shx  = {rx_src, fx};
    assign shy  = {ry_src, fy};
    assign fitx = shx >= {1'b0, d_src};
    assign fity = shy >= {1'b0, d_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[j]   <= fitx ? 33'(shx - {1'b0, d_src}) : shx[32:0];
        ry[j]   <= fity ? 33'(shy - {1'b0, d_src}) : shy[32:0];
        accx[j] <= {qx_src[15:0], fitx};
        accy[j] <= {qy_src[15:0], fity};
        dv[j]   <= d_src;
        side[j] <= s_src;
      end
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign qx        = accx[DIV_STEPS-1];
  assign qy        = accy[DIV_STEPS-1];
  assign dist_out  = dv[DIV_STEPS-1];
  assign side_out  = side[DIV_STEPS-1];

endmodule

>>> hw/rtl/damped_spring_force_pair.sv
// ----------------------------------------------------------------------------
// Damped spring force between two particles
// Hooke spring plus axial damping in Q16.16, pipelined for one pair a cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
// in        in         in_valid / in_ready       in_data (in_t)
// out       out        out_valid / out_ready     out_data (out_t)
//
// One request is taken per cycle while the skid entry is empty.
// The pipeline includes the 33-stage square root and the 17-stage divider.
// Reset clears all valid bits and the coefficient registers.
// An output register with a skid entry holds results while out_ready is low;
// the pipeline stalls only once the skid entry is full.
// ----------------------------------------------------------------------------
module damped_spring_force_pair (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  dsfp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dsfp_pkg::out_t out_data
);
  import dsfp_pkg::*;

  function automatic logic [32:0] clamp_force(input logic [54:0] p, input logic neg);
    logic [32:0] r;
    r = '0;
    if (p == '0) begin
      r = '0;
    end else if (neg) begin
      if (p > 55'h80000000) begin
        r = {1'b1, 32'h80000000};
      end else begin
        r = {1'b0, 32'd0 - p[31:0]};
      end
    end else begin
      if (p > 55'h7FFFFFFF) begin
        r = {1'b1, 32'h7FFFFFFF};
      end else begin
        r = {1'b0, p[31:0]};
      end
    end
    return r;
  endfunction

  logic [31:0] stiffness;
  logic [31:0] damping;
  logic [30:0] rest_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= '0;
      damping     <= '0;
      rest_length <= '0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_STIFFNESS:   stiffness   <= cfg_data;
        REG_DAMPING:     damping     <= cfg_data;
        REG_REST_LENGTH: rest_length <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v;
  out_t skid_data;

  assign en       = !skid_v;
  assign in_ready = en;

  // Stage 1: differences and magnitudes.
  logic signed [32:0] dx_c, dy_c, dvx_c, dvy_c;
  logic [32:0]        ax_c, ay_c;

  assign dx_c  = {in_data.second_pos_x[31], in_data.second_pos_x}
               - {in_data.first_pos_x[31], in_data.first_pos_x};
  assign dy_c  = {in_data.second_pos_y[31], in_data.second_pos_y}
               - {in_data.first_pos_y[31], in_data.first_pos_y};
  assign dvx_c = {in_data.second_vel_x[31], in_data.second_vel_x}
               - {in_data.first_vel_x[31], in_data.first_vel_x};
  assign dvy_c = {in_data.second_vel_y[31], in_data.second_vel_y}
               - {in_data.first_vel_y[31], in_data.first_vel_y};
  assign ax_c  = dx_c[32] ? 33'(-dx_c) : dx_c;
  assign ay_c  = dy_c[32] ? 33'(-dy_c) : dy_c;

  logic       s1_v;
  root_side_t s1_side;

  // Stage 2: squares.
  logic       s2_v;
  logic [63:0] s2_sqx, s2_sqy;
  root_side_t s2_side;

  // Stage 3: sum of squares.
  logic       s3_v;
  logic [64:0] s3_sum;
  root_side_t s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.ax       <= ax_c[31:0];
      s1_side.ay       <= ay_c[31:0];
      s1_side.vel.sx   <= dx_c[32];
      s1_side.vel.sy   <= dy_c[32];
      s1_side.vel.dvx  <= dvx_c;
      s1_side.vel.dvy  <= dvy_c;
      s1_side.vel.coin <= (dx_c == '0) && (dy_c == '0);
      s2_sqx  <= s1_side.ax * s1_side.ax;
      s2_sqy  <= s1_side.ay * s1_side.ay;
      s2_side <= s1_side;
      s3_sum  <= {1'b0, s2_sqx} + {1'b0, s2_sqy};
      s3_side <= s2_side;
    end
  end

  logic        rt_v;
  logic [32:0] rt_d;
  root_side_t  rt_side;

  dsfp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_v),
    .radicand (s3_sum),
    .side_in  (s3_side),
    .out_valid(rt_v),
    .root     (rt_d),
    .side_out (rt_side)
  );

  logic        dq_v;
  logic [16:0] dq_x, dq_y;
  logic [32:0] dq_d;
  vel_side_t   dq_side;

  dsfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rt_v),
    .dist_in  (rt_d),
    .side_in  (rt_side),
    .out_valid(dq_v),
    .qx       (dq_x),
    .qy       (dq_y),
    .dist_out (dq_d),
    .side_out (dq_side)
  );

  // Stage 4: signed direction, velocity products, stretch.
  logic signed [17:0] nx_c, ny_c;
  assign nx_c = dq_side.sx ? -$signed({1'b0, dq_x}) : $signed({1'b0, dq_x});
  assign ny_c = dq_side.sy ? -$signed({1'b0, dq_y}) : $signed({1'b0, dq_y});

  logic               s4_v;
  logic signed [50:0] s4_px, s4_py;
  logic signed [33:0] s4_s;
  logic signed [17:0] s4_nx, s4_ny;
  logic               s4_coin;

  // Stage 5: relative speed along the axis, spring product.
  logic signed [51:0] dot_c;
  logic signed [51:0] dot_b;
  logic [33:0]        smag_c;
  assign dot_c  = {s4_px[50], s4_px} + {s4_py[50], s4_py};
  assign dot_b  = dot_c + (dot_c[51] ? 52'sd65535 : 52'sd0);
  assign smag_c = s4_s[33] ? 34'(-s4_s) : s4_s;

  logic               s5_v;
  logic signed [35:0] s5_vr;
  logic [65:0]        s5_ks;
  logic               s5_sneg;
  logic signed [17:0] s5_nx, s5_ny;
  logic               s5_coin;

  // Stage 6: damping product, signed spring term.
  logic [35:0] vmag_c;
  assign vmag_c = s5_vr[35] ? 36'(-s5_vr) : s5_vr;

  logic               s6_v;
  logic [67:0]        s6_dp;
  logic signed [53:0] s6_spring;
  logic               s6_vneg;
  logic signed [17:0] s6_nx, s6_ny;
  logic               s6_coin;

  // Stage 7: total axial magnitude.
  logic signed [53:0] damp_c;
  assign damp_c = s6_vneg ? -$signed({2'b00, s6_dp[67:16]}) : $signed({2'b00, s6_dp[67:16]});

  logic               s7_v;
  logic signed [53:0] s7_m;
  logic signed [17:0] s7_nx, s7_ny;
  logic               s7_coin;

  // Stage 8: force products.
  logic [53:0] mmag_c;
  logic [16:0] nxmag_c, nymag_c;
  assign mmag_c  = s7_m[53] ? 54'(-s7_m) : s7_m;
  assign nxmag_c = s7_nx[17] ? 17'(-s7_nx) : s7_nx[16:0];
  assign nymag_c = s7_ny[17] ? 17'(-s7_ny) : s7_ny[16:0];

  logic        s8_v;
  logic [70:0] s8_prx, s8_pry;
  logic        s8_negx, s8_negy;
  logic        s8_coin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
      s8_v <= 1'b0;
    end else if (en) begin
      s4_v <= dq_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_px   <= dq_side.dvx * nx_c;
      s4_py   <= dq_side.dvy * ny_c;
      s4_s    <= $signed({1'b0, dq_d}) - $signed({3'b000, rest_length});
      s4_nx   <= nx_c;
      s4_ny   <= ny_c;
      s4_coin <= dq_side.coin;

      s5_vr   <= dot_b[51:16];
      s5_ks   <= stiffness * smag_c;
      s5_sneg <= s4_s[33];
      s5_nx   <= s4_nx;
      s5_ny   <= s4_ny;
      s5_coin <= s4_coin;

      s6_dp     <= damping * vmag_c;
      s6_spring <= s5_sneg ? -$signed({4'b0000, s5_ks[65:16]})
                           : $signed({4'b0000, s5_ks[65:16]});
      s6_vneg   <= s5_vr[35];
      s6_nx     <= s5_nx;
      s6_ny     <= s5_ny;
      s6_coin   <= s5_coin;

      s7_m    <= -(s6_spring + damp_c);
      s7_nx   <= s6_nx;
      s7_ny   <= s6_ny;
      s7_coin <= s6_coin;

      s8_prx  <= mmag_c * nxmag_c;
      s8_pry  <= mmag_c * nymag_c;
      s8_negx <= s7_m[53] ^ s7_nx[17];
      s8_negy <= s7_m[53] ^ s7_ny[17];
      s8_coin <= s7_coin;
    end
  end

  logic [32:0] fx_c, fy_c;
  out_t        res_c;

  assign fx_c = clamp_force(s8_prx[70:16], s8_negx);
  assign fy_c = clamp_force(s8_pry[70:16], s8_negy);

  always_comb begin
    res_c.force_x    = s8_coin ? 32'sd0 : $signed(fx_c[31:0]);
    res_c.force_y    = s8_coin ? 32'sd0 : $signed(fy_c[31:0]);
    res_c.coincident = s8_coin;
    res_c.saturated  = !s8_coin && (fx_c[32] || fy_c[32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= s8_v;
      end
    end else if (!skid_v && s8_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_v ? skid_data : res_c;
    end else if (!skid_v) begin
      skid_data <= res_c;
    end
  end

endmodule

>>> hw/rtl/dsfp_checker.sv
// ----------------------------------------------------------------------------
// Damped spring force port checker
// Concurrent checks on the result channel of the top level.
// ----------------------------------------------------------------------------
module dsfp_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input dsfp_pkg::out_t out_data
);
  import dsfp_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result request dropped while stalled.");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("Result payload changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid right after reset.");

  a_coincident_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.coincident |->
      out_data.force_x == 32'sd0 && out_data.force_y == 32'sd0 && !out_data.saturated)
    else $error("Coincident result carries force or saturation.");

  a_saturated_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      out_data.force_x == 32'sh80000000 || out_data.force_x == 32'sh7FFFFFFF ||
      out_data.force_y == 32'sh80000000 || out_data.force_y == 32'sh7FFFFFFF)
    else $error("Saturated result has no clamped component.");

endmodule

bind damped_spring_force_pair dsfp_checker u_dsfp_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
